// ===== sv/cttw_pkg.sv =====
// Shared types, constants and the raised-cosine gain function for the taper window.
package cttw_pkg;

   // Fixed field widths
   localparam int TAG_BITS       = 10;
   localparam int GAIN_BITS      = 17;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_UP_END     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_DOWN_START = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRACE_LENGTH    = 2'd2;

   // Q1.16 gain constants
   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 17'h10000;
   localparam logic [GAIN_BITS-1:0] ZERO_GAIN  = 17'h00000;
   localparam int ROUND_HALF = 32768;

   // Q30 constants for building the gain table
   localparam logic [63:0] PIQ30  = 64'd3373259426;
   localparam longint      ONE_Q30 = 64'sd1073741824;
   localparam longint unsigned COS_DIV [10] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
      64'd132, 64'd182, 64'd240, 64'd306, 64'd380
   };

   // Gain region of one sample
   typedef enum logic [1:0] {
      REGION_ZERO,
      REGION_RISE,
      REGION_FLAT,
      REGION_FALL
   } region_type;

   localparam int REGION_BITS = 2;

   // Raised-cosine gain (1 - cos(theta)) / 2 in Q1.16, theta in Q30 radians.
   // Mirror the angle about pi/2 for the upper half of the table.
   function automatic logic [GAIN_BITS-1:0] gain_of_theta(input logic [63:0] theta,
                                                          input logic        mirror);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      longint      cos_val;
      longint      num;
      logic [63:0] g;
      x = mirror ? (PIQ30 - theta) : theta;
      x2 = (x * x) >> 30;
      term = 64'(ONE_Q30);
      sum = ONE_Q30;
      for (int i = 1; i <= 10; i++) begin
         term = ((term * x2) >> 30) / COS_DIV[i-1];
         if (i[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      cos_val = mirror ? -sum : sum;
      num = ONE_Q30 - cos_val + 64'sd16384;
      if (num < 0) begin
         num = 0;
      end
      g = 64'(num) >> 15;
      if (g > 64'(UNITY_GAIN)) begin
         g = 64'(UNITY_GAIN);
      end
      return g[GAIN_BITS-1:0];
   endfunction

endpackage

// ===== sv/cttw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cttw_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cttw_region.sv =====
// Front stage: sorts each sample into its gain region and forms phase offset and span.
module cttw_region #(
   parameter int INDEX_BITS  = 16,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [SAMPLE_BITS-1:0]       in_sample,
   input  logic [INDEX_BITS-1:0]               in_index,
   input  logic [cttw_pkg::TAG_BITS-1:0]       in_tag,
   input  logic [INDEX_BITS-1:0]               ramp_up_end,
   input  logic [INDEX_BITS-1:0]               ramp_down_start,
   input  logic [INDEX_BITS-1:0]               trace_length,
   output logic                                out_valid,
   input  logic                                out_ready,
   output cttw_pkg::region_type                out_region,
   output logic [INDEX_BITS-1:0]               out_offset,
   output logic [INDEX_BITS-1:0]               out_span,
   output logic signed [SAMPLE_BITS-1:0]       out_sample,
   output logic [cttw_pkg::TAG_BITS-1:0]       out_tag
);

   logic                          valid_ff;
   cttw_pkg::region_type          region_ff;
   cttw_pkg::region_type          region_in;
   logic [INDEX_BITS-1:0]         offset_ff;
   logic [INDEX_BITS-1:0]         offset_in;
   logic [INDEX_BITS-1:0]         span_ff;
   logic [INDEX_BITS-1:0]         span_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [cttw_pkg::TAG_BITS-1:0] tag_ff;
   logic                          advance;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   // Check regions in order; first match wins
   always_comb begin
      region_in = cttw_pkg::REGION_ZERO;
      offset_in = '0;
      span_in   = INDEX_BITS'(1);
      if (in_index <= INDEX_BITS'(1)) begin
         region_in = cttw_pkg::REGION_ZERO;
      end else if (in_index < ramp_up_end) begin
         region_in = cttw_pkg::REGION_RISE;
         offset_in = in_index - INDEX_BITS'(1);
         span_in   = ramp_up_end - INDEX_BITS'(1);
      end else if (in_index < ramp_down_start) begin
         region_in = cttw_pkg::REGION_FLAT;
      end else if (in_index < trace_length) begin
         region_in = cttw_pkg::REGION_FALL;
         offset_in = in_index - ramp_down_start;
         span_in   = trace_length - ramp_down_start;
      end
   end

   // Stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         region_ff <= region_in;
         offset_ff <= offset_in;
         span_ff   <= span_in;
         sample_ff <= in_sample;
         tag_ff    <= in_tag;
      end
   end

   assign out_valid  = valid_ff;
   assign out_region = region_ff;
   assign out_offset = offset_ff;
   assign out_span   = span_ff;
   assign out_sample = sample_ff;
   assign out_tag    = tag_ff;

endmodule

// ===== sv/cttw_divider.sv =====
// Pipelined restoring divider: phase = round(D * offset / span), one quotient bit per stage.
module cttw_divider #(
   parameter int INDEX_BITS      = 16,
   parameter int COS_TABLE_DEPTH = 1024,
   parameter int SIDE_BITS       = 44
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [INDEX_BITS-1:0]                 in_offset,
   input  logic [INDEX_BITS-1:0]                 in_span,
   input  logic [SIDE_BITS-1:0]                  in_side,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [$clog2(COS_TABLE_DEPTH+1)-1:0]  out_quotient,
   output logic [SIDE_BITS-1:0]                  out_side
);

   localparam int QB     = $clog2(COS_TABLE_DEPTH + 1);
   localparam int NB     = INDEX_BITS + QB + 1;
   localparam int DB     = INDEX_BITS + 1;
   localparam int STAGES = QB + 1;
   localparam int DEPTH2 = 2 * COS_TABLE_DEPTH;

   logic                 valid_ff [STAGES];
   logic                 valid_in [STAGES];
   logic [NB-1:0]        rem_ff   [STAGES];
   logic [NB-1:0]        rem_in   [STAGES];
   logic [DB-1:0]        den_ff   [STAGES];
   logic [DB-1:0]        den_in   [STAGES];
   logic [QB-1:0]        quo_ff   [STAGES];
   logic [QB-1:0]        quo_in   [STAGES];
   logic [SIDE_BITS-1:0] side_ff  [STAGES];
   logic [SIDE_BITS-1:0] side_in  [STAGES];
   logic [NB-1:0]        trial    [STAGES];
   logic                 en       [STAGES];

   // Stage enables: a stage loads when empty or when its successor moves
   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   assign in_ready = en[0];

   // Form numerator 2*D*offset + span and divisor 2*span, then one bit per stage
   always_comb begin
      valid_in[0] = in_valid;
      rem_in[0]   = NB'(DEPTH2) * NB'(in_offset) + NB'(in_span);
      den_in[0]   = {in_span, 1'b0};
      quo_in[0]   = '0;
      side_in[0]  = in_side;
      trial[0]    = '0;
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         den_in[s]   = den_ff[s-1];
         side_in[s]  = side_ff[s-1];
         trial[s]    = NB'(den_ff[s-1]) << (QB - s);
         quo_in[s]   = quo_ff[s-1];
         if (rem_ff[s-1] >= trial[s]) begin
            rem_in[s]          = rem_ff[s-1] - trial[s];
            quo_in[s][QB - s]  = 1'b1;
         end else begin
            rem_in[s]          = rem_ff[s-1];
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_in[s];
            quo_ff[s]  <= quo_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign out_quotient = quo_ff[STAGES-1];
   assign out_side     = side_ff[STAGES-1];

endmodule

// ===== sv/cttw_gain.sv =====
// Back stages: gain table lookup, gain select, multiply and round; fills the table after reset.
module cttw_gain #(
   parameter int SAMPLE_BITS     = 32,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   output logic                                 fill_done,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [$clog2(COS_TABLE_DEPTH+1)-1:0] in_quotient,
   input  cttw_pkg::region_type                 in_region,
   input  logic signed [SAMPLE_BITS-1:0]        in_sample,
   input  logic [cttw_pkg::TAG_BITS-1:0]        in_tag,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [SAMPLE_BITS-1:0]        out_value,
   output logic [cttw_pkg::TAG_BITS-1:0]        out_tag
);

   localparam int QB    = $clog2(COS_TABLE_DEPTH + 1);
   localparam int GB    = cttw_pkg::GAIN_BITS;
   localparam int PB    = SAMPLE_BITS + GB + 1;
   localparam int NROWS = COS_TABLE_DEPTH + 1;

   // Constant gain table, computed at elaboration
   logic [GB-1:0] rom_const [NROWS];

   for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] THETA = (cttw_pkg::PIQ30 * 64'(k)) / COS_TABLE_DEPTH;
      assign rom_const[k] = cttw_pkg::gain_of_theta(THETA, (2 * k) > COS_TABLE_DEPTH);
   end

   // Table fill sweep after reset
   logic          fill_busy_ff;
   logic [QB-1:0] fill_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff <= 1'b1;
         fill_addr_ff <= '0;
      end else if (fill_busy_ff) begin
         if (fill_addr_ff == QB'(COS_TABLE_DEPTH)) begin
            fill_busy_ff <= 1'b0;
         end else begin
            fill_addr_ff <= fill_addr_ff + QB'(1);
         end
      end
   end

   assign fill_done = !fill_busy_ff;

   // Stage enables
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic en0, en1, en2, en3;

   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;
   assign in_ready = en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= in_valid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Stage 0: clamp phase and read the table
   logic [QB-1:0] rd_addr;
   logic [GB-1:0] rom_data;

   assign rd_addr = (in_quotient > QB'(COS_TABLE_DEPTH)) ? QB'(COS_TABLE_DEPTH) : in_quotient;

   cttw_ram #(
      .WIDTH (GB),
      .DEPTH (NROWS)
   ) u_table (
      .clock   (clock),
      .wr_en   (fill_busy_ff),
      .wr_addr (fill_addr_ff),
      .wr_data (rom_const[fill_addr_ff]),
      .rd_en   (en0),
      .rd_addr (rd_addr),
      .rd_data (rom_data)
   );

   cttw_pkg::region_type          region0_ff;
   logic signed [SAMPLE_BITS-1:0] sample0_ff;
   logic [cttw_pkg::TAG_BITS-1:0] tag0_ff;

   always_ff @(posedge clock) begin
      if (en0) begin
         region0_ff <= in_region;
         sample0_ff <= in_sample;
         tag0_ff    <= in_tag;
      end
   end

   // Stage 1: select gain by region
   logic [GB-1:0]                 gain1_in;
   logic [GB-1:0]                 gain1_ff;
   logic signed [SAMPLE_BITS-1:0] sample1_ff;
   logic [cttw_pkg::TAG_BITS-1:0] tag1_ff;

   always_comb begin
      case (region0_ff)
         cttw_pkg::REGION_RISE: gain1_in = rom_data;
         cttw_pkg::REGION_FLAT: gain1_in = cttw_pkg::UNITY_GAIN;
         cttw_pkg::REGION_FALL: gain1_in = cttw_pkg::UNITY_GAIN - rom_data;
         default:               gain1_in = cttw_pkg::ZERO_GAIN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         gain1_ff   <= gain1_in;
         sample1_ff <= sample0_ff;
         tag1_ff    <= tag0_ff;
      end
   end

   // Stage 2: multiply sample by gain
   logic signed [PB-1:0]          sample_ext;
   logic signed [PB-1:0]          gain_ext;
   logic signed [PB-1:0]          prod2_ff;
   logic [cttw_pkg::TAG_BITS-1:0] tag2_ff;

   assign sample_ext = PB'(sample1_ff);
   assign gain_ext   = PB'({1'b0, gain1_ff});

   always_ff @(posedge clock) begin
      if (en2) begin
         prod2_ff <= sample_ext * gain_ext;
         tag2_ff  <= tag1_ff;
      end
   end

   // Stage 3: round to nearest, ties up, and drop the fraction
   logic signed [PB-1:0]          rounded;
   logic signed [SAMPLE_BITS-1:0] value3_ff;
   logic [cttw_pkg::TAG_BITS-1:0] tag3_ff;

   assign rounded = prod2_ff + PB'(cttw_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      if (en3) begin
         value3_ff <= rounded[SAMPLE_BITS+15:16];
         tag3_ff   <= tag2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_value = value3_ff;
   assign out_tag   = tag3_ff;

endmodule

// ===== sv/cosine_taper_window_top.sv =====
// Top level of the cosine taper window: registers, front stage, divider and gain stages.
//
// Usage:
//  - Input transactions (req_*) carry a signed sample, its one-based index in the
//    trace and a trace number. One output transaction (rsp_*) follows each input:
//    the sample times the taper gain, rounded to nearest, and the trace number.
//  - Both channels use valid/stall; a transaction moves when valid is high and
//    stall is low. The block takes one transaction per cycle while req_stall is low.
//  - The pipeline runs region decode, a numerator stage plus one divider stage per
//    phase bit, then table read, gain select, multiply and rounding.
//  - Each stage carries its own valid bit and loads when empty or when the next
//    stage moves, so a stalled receiver backs the pipeline up stage by stage and
//    input keeps flowing into empty stages; nothing is dropped or repeated.
//  - After reset the gain table is written from constants, one entry a cycle, all
//    COS_TABLE_DEPTH+1 entries (1025 by default), with req_stall held high.
//    Reset also sets ramp_up_end to 1 and the other two registers to 65535.
//  - csr_write_enable writes csr_write_data to register csr_index (0: ramp_up_end,
//    1: ramp_down_start, 2: trace_length); write only while the block is empty.
module cosine_taper_window_top #(
   parameter int INDEX_BITS      = 16,
   parameter int SAMPLE_BITS     = 32,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [SAMPLE_BITS-1:0]             req_sample_value,
   input  logic [INDEX_BITS-1:0]                     req_sample_index,
   input  logic [cttw_pkg::TAG_BITS-1:0]             req_trace_number,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]             rsp_tapered_value,
   output logic [cttw_pkg::TAG_BITS-1:0]             rsp_trace_tag,
   input  logic                                      csr_write_enable,
   input  logic [cttw_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [INDEX_BITS-1:0]                     csr_write_data
);

   localparam int QB        = $clog2(COS_TABLE_DEPTH + 1);
   localparam int SIDE_BITS = cttw_pkg::REGION_BITS + SAMPLE_BITS + cttw_pkg::TAG_BITS;

   // Configuration registers
   logic [INDEX_BITS-1:0] ramp_up_end_ff;
   logic [INDEX_BITS-1:0] ramp_down_start_ff;
   logic [INDEX_BITS-1:0] trace_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_up_end_ff     <= INDEX_BITS'(1);
         ramp_down_start_ff <= INDEX_BITS'(65535);
         trace_length_ff    <= INDEX_BITS'(65535);
      end else if (csr_write_enable) begin
         case (csr_index)
            cttw_pkg::CSR_RAMP_UP_END:     ramp_up_end_ff     <= csr_write_data;
            cttw_pkg::CSR_RAMP_DOWN_START: ramp_down_start_ff <= csr_write_data;
            cttw_pkg::CSR_TRACE_LENGTH:    trace_length_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Hold input off until the table is filled
   logic fill_done;
   logic front_ready;

   assign req_stall = !front_ready || !fill_done;

   // Region decode
   logic                          reg_valid;
   logic                          reg_ready;
   cttw_pkg::region_type          reg_region;
   logic [INDEX_BITS-1:0]         reg_offset;
   logic [INDEX_BITS-1:0]         reg_span;
   logic signed [SAMPLE_BITS-1:0] reg_sample;
   logic [cttw_pkg::TAG_BITS-1:0] reg_tag;

   cttw_region #(
      .INDEX_BITS  (INDEX_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_region (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid && fill_done),
      .in_ready        (front_ready),
      .in_sample       (req_sample_value),
      .in_index        (req_sample_index),
      .in_tag          (req_trace_number),
      .ramp_up_end     (ramp_up_end_ff),
      .ramp_down_start (ramp_down_start_ff),
      .trace_length    (trace_length_ff),
      .out_valid       (reg_valid),
      .out_ready       (reg_ready),
      .out_region      (reg_region),
      .out_offset      (reg_offset),
      .out_span        (reg_span),
      .out_sample      (reg_sample),
      .out_tag         (reg_tag)
   );

   // Phase division, sample and tag travel alongside
   logic [SIDE_BITS-1:0] div_side_in;
   logic [SIDE_BITS-1:0] div_side_out;
   logic                 div_valid;
   logic                 div_ready;
   logic [QB-1:0]        div_quotient;

   assign div_side_in = {reg_region, reg_sample, reg_tag};

   cttw_divider #(
      .INDEX_BITS      (INDEX_BITS),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
      .SIDE_BITS       (SIDE_BITS)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (reg_valid),
      .in_ready     (reg_ready),
      .in_offset    (reg_offset),
      .in_span      (reg_span),
      .in_side      (div_side_in),
      .out_valid    (div_valid),
      .out_ready    (div_ready),
      .out_quotient (div_quotient),
      .out_side     (div_side_out)
   );

   // Unpack the sideband
   cttw_pkg::region_type          div_region;
   logic signed [SAMPLE_BITS-1:0] div_sample;
   logic [cttw_pkg::TAG_BITS-1:0] div_tag;

   assign div_region = cttw_pkg::region_type'(div_side_out[SIDE_BITS-1 -: cttw_pkg::REGION_BITS]);
   assign div_sample = div_side_out[cttw_pkg::TAG_BITS +: SAMPLE_BITS];
   assign div_tag    = div_side_out[cttw_pkg::TAG_BITS-1:0];

   // Table lookup, gain and scaling
   cttw_gain #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_gain (
      .clock       (clock),
      .reset       (reset),
      .fill_done   (fill_done),
      .in_valid    (div_valid),
      .in_ready    (div_ready),
      .in_quotient (div_quotient),
      .in_region   (div_region),
      .in_sample   (div_sample),
      .in_tag      (div_tag),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_value   (rsp_tapered_value),
      .out_tag     (rsp_trace_tag)
   );

endmodule

// ===== sv/cttw_checker.sv =====
// Port-level checks for the cosine taper window, bound to the top level.
module cttw_checker #(
   parameter int SAMPLE_BITS = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [SAMPLE_BITS-1:0]        rsp_tapered_value,
   input logic [cttw_pkg::TAG_BITS-1:0] rsp_trace_tag
);

   // Hold a stalled result valid
   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped its valid");

   // Hold a stalled result payload
   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_tapered_value) && $stable(rsp_trace_tag))
      else $error("stalled result payload changed");

   // Refuse input straight after reset, as the gain table fill begins
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken before gain table fill");

   // Drain all results on reset
   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind cosine_taper_window_top cttw_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_cttw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_tapered_value (rsp_tapered_value),
   .rsp_trace_tag     (rsp_trace_tag)
);

// ===== tb/sv/cosine_taper_window_top_test.sv =====
// Self-checking testbench for the cosine taper window: stimulus, gain prediction and result checks.
`timescale 1ns / 100ps

module cosine_taper_window_top_test;

   localparam int INDEX_W     = 16;
   localparam int SAMPLE_W    = 32;
   localparam int TABLE_DEPTH = 1024;
   localparam int LATENCY     = $clog2(TABLE_DEPTH + 1) + 6;
   localparam int SETTLE      = LATENCY + 8;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 170;
   localparam int RANDOM_PHASES = 12;
   localparam int UNITY_Q16   = 65536;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam logic [cttw_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_BLOCKS} rx_mode_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0]          sample;
      logic [INDEX_W-1:0]                  index;
      logic [cttw_pkg::TAG_BITS-1:0]       trace;
      bit                                  wait_idle;
   } sample_item_type;

   typedef struct {
      logic [SAMPLE_W-1:0]           value;
      logic [cttw_pkg::TAG_BITS-1:0] tag;
   } taper_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic [INDEX_W-1:0] req_sample_index = '0;
   logic [cttw_pkg::TAG_BITS-1:0] req_trace_number = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_tapered_value;
   logic [cttw_pkg::TAG_BITS-1:0] rsp_trace_tag;
   logic csr_write_enable = 1'b0;
   logic [cttw_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [INDEX_W-1:0] csr_write_data = '0;

   // Shadow copy of the taper registers and the raised-cosine gain table
   logic [INDEX_W-1:0] ramp_up_end_q = 16'd1;
   logic [INDEX_W-1:0] ramp_down_start_q = 16'd65535;
   logic [INDEX_W-1:0] trace_length_q = 16'd65535;
   int cos_gain [0:TABLE_DEPTH];

   sample_item_type  pending_samples [$];
   taper_result_type expected_taper [$];

   int mismatch_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int setting_count = 0;
   int zone_hits [4] = '{0, 0, 0, 0};
   int cycle_count = 0;

   cosine_taper_window_top #(
      .INDEX_BITS(INDEX_W),
      .SAMPLE_BITS(SAMPLE_W),
      .COS_TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_value(req_sample_value),
      .req_sample_index(req_sample_index),
      .req_trace_number(req_trace_number),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tapered_value(rsp_tapered_value),
      .rsp_trace_tag(rsp_trace_tag),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Cosine in Q30 by an eleven-term Taylor series, truncating at every step
   function automatic longint q30_cosine(input logic [63:0] angle);
      logic [63:0] sq;
      logic [63:0] term;
      longint acc;
      sq = (angle * angle) >> 30;
      term = ONE_Q30;
      acc = longint'(ONE_Q30);
      for (int k = 1; k <= 10; k++) begin
         term = ((term * sq) >> 30) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      return acc;
   endfunction

   // Fill the Q1.16 table of (1 - cos)/2, folding the upper half about pi/2
   function automatic void build_cos_gain();
      logic [63:0] theta;
      longint c;
      longint num;
      longint g;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
         theta = (PI_Q30 * 64'(k)) / 64'(TABLE_DEPTH);
         if (2 * k > TABLE_DEPTH) begin
            c = -q30_cosine(PI_Q30 - theta);
         end else begin
            c = q30_cosine(theta);
         end
         num = longint'(ONE_Q30) - c + 16384;
         if (num < 0) begin
            num = 0;
         end
         g = num >>> 15;
         if (g > UNITY_Q16) begin
            g = UNITY_Q16;
         end
         cos_gain[k] = int'(g);
      end
   endfunction

   // Table position for an offset within a flank, rounded to nearest
   function automatic int flank_phase(input longint unsigned off, input longint unsigned span);
      longint unsigned p;
      p = (2 * TABLE_DEPTH * off + span) / (2 * span);
      if (p > TABLE_DEPTH) begin
         p = TABLE_DEPTH;
      end
      return int'(p);
   endfunction

   // Gain for a sample position; regions are tried in order, first match wins
   function automatic int taper_gain(input logic [INDEX_W-1:0] n,
                                     output cttw_pkg::region_type zone);
      longint unsigned pos;
      longint unsigned up;
      longint unsigned down;
      longint unsigned len;
      pos = n;
      up = ramp_up_end_q;
      down = ramp_down_start_q;
      len = trace_length_q;
      zone = cttw_pkg::REGION_ZERO;
      if (pos <= 1) begin
         return 0;
      end
      if (pos < up) begin
         zone = cttw_pkg::REGION_RISE;
         return cos_gain[flank_phase(pos - 1, up - 1)];
      end
      if (pos < down) begin
         zone = cttw_pkg::REGION_FLAT;
         return UNITY_Q16;
      end
      if (pos < len) begin
         zone = cttw_pkg::REGION_FALL;
         return UNITY_Q16 - cos_gain[flank_phase(pos - down, len - down)];
      end
      return 0;
   endfunction

   // Expected output transaction: sample times gain, ties rounded upward
   function automatic taper_result_type predict_taper(
         input logic signed [SAMPLE_W-1:0]    s,
         input logic [INDEX_W-1:0]            n,
         input logic [cttw_pkg::TAG_BITS-1:0] trace);
      taper_result_type r;
      cttw_pkg::region_type zone;
      int gain;
      longint prod;
      gain = taper_gain(n, zone);
      zone_hits[zone]++;
      prod = (longint'(s) * longint'(gain) + 64'sd32768) >>> 16;
      r.value = prod[SAMPLE_W-1:0];
      r.tag = trace;
      return r;
   endfunction

   task automatic report_fault(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("MISMATCH: %s", msg);
      end
   endtask

   // Write one register and track it in the shadow copy
   task automatic write_reg(input logic [cttw_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [INDEX_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      case (idx)
         cttw_pkg::CSR_RAMP_UP_END:     ramp_up_end_q = val;
         cttw_pkg::CSR_RAMP_DOWN_START: ramp_down_start_q = val;
         cttw_pkg::CSR_TRACE_LENGTH:    trace_length_q = val;
         default: ;
      endcase
   endtask

   // Drain the block, let the pipeline settle, then load a new taper setting, optionally poking the spare index
   task automatic configure(input logic [INDEX_W-1:0] up, input logic [INDEX_W-1:0] down,
                            input logic [INDEX_W-1:0] len, input bit poke_spare);
      while (pending_samples.size() != 0 || req_valid || expected_taper.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
      write_reg(cttw_pkg::CSR_RAMP_UP_END, up);
      write_reg(cttw_pkg::CSR_RAMP_DOWN_START, down);
      write_reg(cttw_pkg::CSR_TRACE_LENGTH, len);
      if (poke_spare) begin
         write_reg(CSR_SPARE_INDEX, 16'($urandom));
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
      setting_count++;
   endtask

   task automatic queue_item(input logic signed [SAMPLE_W-1:0] s, input logic [INDEX_W-1:0] n,
                             input logic [cttw_pkg::TAG_BITS-1:0] trace, input bit wait_idle);
      sample_item_type it;
      it.sample = s;
      it.index = n;
      it.trace = trace;
      it.wait_idle = wait_idle;
      pending_samples.push_back(it);
   endtask

   // Mostly positions up to just past the highest configured border, some near region borders, some anywhere
   function automatic logic [INDEX_W-1:0] pick_index();
      int unsigned roll;
      int unsigned top;
      logic [INDEX_W-1:0] base;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         return INDEX_W'($urandom);
      end
      if (roll < 30) begin
         case ($urandom_range(0, 3))
            0: base = 16'd1;
            1: base = ramp_up_end_q;
            2: base = ramp_down_start_q;
            default: base = trace_length_q;
         endcase
         return INDEX_W'(base + $urandom_range(0, 2) - 1);
      end
      top = ramp_up_end_q;
      if (ramp_down_start_q > top) top = ramp_down_start_q;
      if (trace_length_q > top) top = trace_length_q;
      top = top + 3;
      if (top > 65535) top = 65535;
      return INDEX_W'($urandom_range(0, top));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '1;
            3: return '0;
            default: return 32'd1;
         endcase
      end
      if (roll < 30) begin
         return int'($urandom_range(0, 2000)) - 1000;
      end
      return $urandom;
   endfunction

   // Driver: bursts of transactions separated by random gaps
   int burst_left = 8;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_taper.push_back(predict_taper(req_sample_value, req_sample_index,
                                                   req_trace_number));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() == 0 ||
                         (pending_samples[0].wait_idle && expected_taper.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_sample_value <= pending_samples[0].sample;
               req_sample_index <= pending_samples[0].index;
               req_trace_number <= pending_samples[0].trace;
               void'(pending_samples.pop_front());
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 24);
                  gap_left = $urandom_range(1, 10);
               end
            end
         end
      end
   end

   // Monitor: check each output transaction against the oldest prediction
   rx_mode_type rx_mode = RX_FLOW;
   int rx_left = 0;
   always @(posedge clock) begin
      taper_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_taper.size() == 0) begin
               report_fault($sformatf("unexpected result value %0d tag %0d",
                                      $signed(rsp_tapered_value), rsp_trace_tag));
            end else begin
               want = expected_taper.pop_front();
               checked_count++;
               if (rsp_tapered_value !== want.value) begin
                  report_fault($sformatf("tapered_value (tag %0d) expected %0d got %0d",
                                         want.tag, $signed(want.value),
                                         $signed(rsp_tapered_value)));
               end
               if (rsp_trace_tag !== want.tag) begin
                  report_fault($sformatf("trace_tag expected %0d got %0d",
                                         want.tag, rsp_trace_tag));
               end
            end
         end
         // advance the stall pattern
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            RX_FLOW:   rsp_stall <= 1'b0;
            RX_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:  rsp_stall <= ($urandom_range(0, 1) == 0);
            default:   rsp_stall <= (rx_left % 16 < 10);
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d predictions outstanding",
                  cycle_count, expected_taper.size());
         $display("cosine_taper_window_top verification failed");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      logic [INDEX_W-1:0] up;
      logic [INDEX_W-1:0] down;
      logic [INDEX_W-1:0] len;
      build_cos_gain();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // hold off until the gain table fill is done
      do @(posedge clock); while (req_stall);

      // reset setting: unity everywhere but the ends
      queue_item(32'sh7FFF_FFFF, 16'd2, 10'd0, 1'b0);
      queue_item(32'sh8000_0000, 16'd65535, 10'd1023, 1'b0);
      queue_item(32'sd12345, 16'd0, 10'd5, 1'b0);

      // ordered flanks: walk every region and its borders
      configure(16'd9, 16'd20, 16'd30, 1'b0);
      queue_item(32'sh7FFF_FFFF, 16'd1, 10'd1, 1'b0);
      queue_item(32'sh8000_0000, 16'd2, 10'd2, 1'b0);
      queue_item(32'sh7FFF_FFFF, 16'd5, 10'd3, 1'b0);
      queue_item(-32'sd1, 16'd8, 10'd4, 1'b0);
      queue_item(32'sh8000_0000, 16'd9, 10'd5, 1'b0);
      queue_item(32'sd1, 16'd15, 10'd6, 1'b0);
      queue_item(32'sh7FFF_FFFF, 16'd19, 10'd7, 1'b0);
      queue_item(32'sh8000_0000, 16'd20, 10'd8, 1'b0);
      queue_item(32'sh7FFF_FFFF, 16'd25, 10'd9, 1'b0);
      queue_item(32'sh8000_0000, 16'd29, 10'd10, 1'b1);
      queue_item(32'sh7FFF_FFFF, 16'd30, 10'd11, 1'b0);
      queue_item(32'sh8000_0000, 16'd31, 10'd1023, 1'b0);

      // all registers zero, plus a write to the unused index
      configure(16'd0, 16'd0, 16'd0, 1'b1);
      queue_item(32'sh7FFF_FFFF, 16'd0, 10'd12, 1'b0);
      queue_item(32'sh8000_0000, 16'd3, 10'd13, 1'b0);
      queue_item(-32'sd1, 16'd65535, 10'd14, 1'b0);

      // falling flank starts past the trace length: unity runs on beyond it
      configure(16'd12, 16'd40, 16'd25, 1'b0);
      queue_item(32'sh7FFF_FFFF, 16'd30, 10'd15, 1'b0);
      queue_item(32'sh8000_0000, 16'd45, 10'd16, 1'b0);
      queue_item(32'sh7FFF_FFFF, 16'd6, 10'd17, 1'b0);

      // random phases, the extreme settings first
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin up = 16'd65535; down = 16'd65535; len = 16'd65535; end
            1: begin up = 16'd2; down = 16'd3; len = 16'd4; end
            2: begin up = 16'd1; down = 16'd1; len = 16'd1; end
            3: begin up = 16'd0; down = 16'd0; len = 16'd65535; end
            4: begin up = 16'd300; down = 16'd40000; len = 16'd65535; end
            5: begin up = 16'd50; down = 16'd30; len = 16'd20; end
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  up = INDEX_W'($urandom);
                  down = INDEX_W'($urandom);
                  len = INDEX_W'($urandom);
               end else begin
                  up = INDEX_W'($urandom_range(1, 200));
                  down = INDEX_W'(up + $urandom_range(0, 300));
                  len = INDEX_W'(down + $urandom_range(1, 300));
               end
            end
         endcase
         configure(up, down, len, 1'($urandom_range(0, 1)));
         repeat (PHASE_ITEMS) begin
            queue_item(pick_sample(), pick_index(),
                       cttw_pkg::TAG_BITS'($urandom_range(0, 1023)),
                       $urandom_range(0, 299) == 0);
         end
      end

      // wait for the last results, then watch for strays
      while (pending_samples.size() != 0 || req_valid || expected_taper.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
      if (expected_taper.size() != 0) begin
         report_fault($sformatf("%0d predictions never answered", expected_taper.size()));
      end

      $display("Sent %0d samples over %0d register settings; %0d results checked, %0d faults",
               sent_count, setting_count + 1, checked_count, mismatch_count);
      $display("Gain regions hit: zero %0d, rising %0d, unity %0d, falling %0d",
               zone_hits[cttw_pkg::REGION_ZERO], zone_hits[cttw_pkg::REGION_RISE],
               zone_hits[cttw_pkg::REGION_FLAT], zone_hits[cttw_pkg::REGION_FALL]);
      if (mismatch_count == 0) begin
         $display("cosine_taper_window_top verification clean");
      end else begin
         $display("cosine_taper_window_top verification failed");
      end
      $finish;
   end

endmodule
